@@ sv/ets_pkg.sv @@
// shared types and constants of the expression token scanner
package ets_pkg;

	// bundles held in the queue between front and back
	localparam int ETS_QUEUE_DEPTH = 4;
	// most results one input beat can cause
	localparam int ETS_MAX_RESULTS = 4;
	localparam int ETS_RES_IDX_W = $clog2(ETS_MAX_RESULTS);

	// token kinds
	typedef enum logic [4:0] {
		KIND_END    = 5'd0,
		KIND_DEC    = 5'd1,
		KIND_BIN    = 5'd2,
		KIND_HEX    = 5'd3,
		KIND_LPAREN = 5'd4,
		KIND_RPAREN = 5'd5,
		KIND_PLUS   = 5'd6,
		KIND_MINUS  = 5'd7,
		KIND_MUL    = 5'd8,
		KIND_DIV    = 5'd9,
		KIND_NOT    = 5'd10,
		KIND_AND    = 5'd11,
		KIND_OR     = 5'd12,
		KIND_XOR    = 5'd13,
		KIND_LSL    = 5'd14,
		KIND_LSR    = 5'd15,
		KIND_ASR    = 5'd16,
		KIND_ERR    = 5'd17
	} kind_t;

	// input beat
	typedef struct packed {
		logic [7:0] char_byte;
		logic       byte_present;
		logic       input_last;
	} in_t;

	// output beat
	typedef struct packed {
		logic [4:0] token_kind;
		logic [7:0] text_byte;
		logic       text_valid;
		logic       token_end;
		logic       run_last;
	} result_t;

	// all results of one input beat, slots 0..last_idx in order
	typedef struct packed {
		logic [ETS_RES_IDX_W-1:0]          last_idx;
		result_t [ETS_MAX_RESULTS-1:0]     res;
	} bundle_t;

endpackage

@@ sv/ets_front.sv @@
// front end: takes characters, tracks the scan mode and builds result bundles
module ets_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ets_pkg::in_t     in_data,
	output logic             in_stall,
	input  logic             q_full,
	output logic             push,
	output ets_pkg::bundle_t push_data
);
	import ets_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_DEC   = 3'd1,
		MODE_BIN   = 3'd2,
		MODE_HEX   = 3'd3,
		MODE_ZERO  = 3'd4,
		MODE_LT    = 3'd5,
		MODE_GT    = 3'd6,
		MODE_DRAIN = 3'd7
	} mode_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DIV    = 8'h2f;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_XOR    = 8'h5e;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_AND    = 8'h26;
	localparam logic [7:0] CH_OR     = 8'h7c;
	localparam logic [7:0] CH_NOT    = 8'h7e;

	localparam int CNT_W = $clog2(ETS_MAX_RESULTS + 1);

	typedef struct packed {
		mode_t                         mode;
		logic [CNT_W-1:0]              cnt;
		result_t [ETS_MAX_RESULTS-1:0] res;
	} work_t;

	mode_t mode_q;
	work_t step;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
			((c >= CH_UC_A) && (c <= CH_UC_F));
	endfunction

	// kind of a one-character operator, end kind when none
	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_MUL:    k = KIND_MUL;
			CH_DIV:    k = KIND_DIV;
			CH_NOT:    k = KIND_NOT;
			CH_AND:    k = KIND_AND;
			CH_OR:     k = KIND_OR;
			CH_XOR:    k = KIND_XOR;
			default:   k = KIND_END;
		endcase
		return k;
	endfunction

	function automatic kind_t lit_kind(input mode_t m);
		kind_t k;
		unique case (m)
			MODE_BIN: k = KIND_BIN;
			MODE_HEX: k = KIND_HEX;
			default:  k = KIND_DEC;
		endcase
		return k;
	endfunction

	// append one result
	function automatic work_t emit(input work_t w, input kind_t k, input logic [7:0] t,
			input logic v, input logic e);
		work_t r;
		r = w;
		r.res[r.cnt[ETS_RES_IDX_W-1:0]] = '{token_kind: k, text_byte: v ? t : 8'd0,
			text_valid: v, token_end: e, run_last: 1'b0};
		r.cnt = r.cnt + CNT_W'(1);
		return r;
	endfunction

	// first character of a new token
	function automatic work_t start_tok(input work_t w, input logic [7:0] c);
		work_t r;
		kind_t k;
		r = w;
		k = single_kind(c);
		if (c == CH_SPACE || c == CH_TAB) begin
			r.mode = MODE_IDLE;
		end else if (c == CH_ZERO) begin
			r.mode = MODE_ZERO;
		end else if (is_dec(c)) begin
			r = emit(r, KIND_DEC, c, 1'b1, 1'b0);
			r.mode = MODE_DEC;
		end else if (c == CH_LT) begin
			r.mode = MODE_LT;
		end else if (c == CH_GT) begin
			r.mode = MODE_GT;
		end else if (k != KIND_END) begin
			r = emit(r, k, c, 1'b1, 1'b1);
			r.mode = MODE_IDLE;
		end else begin
			r = emit(r, KIND_ERR, c, 1'b1, 1'b1);
			r.mode = MODE_DRAIN;
		end
		return r;
	endfunction

	// one character step plus end of expression
	always_comb begin
		logic  [7:0] c;
		logic        more;
		kind_t       lk;
		c = in_data.char_byte;
		step = '0;
		step.mode = mode_q;
		lk = lit_kind(mode_q);
		more = 1'b0;
		if (in_data.byte_present) begin
			unique case (mode_q)
				MODE_IDLE: step = start_tok(step, c);
				MODE_DEC, MODE_BIN, MODE_HEX: begin
					more = (mode_q == MODE_DEC) ? is_dec(c) :
						(mode_q == MODE_BIN) ? (c == CH_ZERO || c == CH_ONE) : is_hex(c);
					if (more) begin
						step = emit(step, lk, c, 1'b1, 1'b0);
					end else begin
						step = emit(step, lk, 8'd0, 1'b0, 1'b1);
						step = start_tok(step, c);
					end
				end
				MODE_ZERO: begin
					if (c == CH_LC_B) begin
						step.mode = MODE_BIN;
					end else if (c == CH_LC_X) begin
						step.mode = MODE_HEX;
					end else if (is_dec(c)) begin
						step = emit(step, KIND_DEC, CH_ZERO, 1'b1, 1'b0);
						step = emit(step, KIND_DEC, c, 1'b1, 1'b0);
						step.mode = MODE_DEC;
					end else begin
						step = emit(step, KIND_DEC, CH_ZERO, 1'b1, 1'b1);
						step = start_tok(step, c);
					end
				end
				MODE_LT: begin
					if (c == CH_LT) begin
						step = emit(step, KIND_LSL, CH_LT, 1'b1, 1'b0);
						step = emit(step, KIND_LSL, CH_LT, 1'b1, 1'b1);
						step.mode = MODE_IDLE;
					end else begin
						step = emit(step, KIND_ERR, CH_LT, 1'b1, 1'b1);
						step.mode = MODE_DRAIN;
					end
				end
				MODE_GT: begin
					if (c == CH_GT || c == CH_MINUS) begin
						step = emit(step, (c == CH_GT) ? KIND_LSR : KIND_ASR, CH_GT,
							1'b1, 1'b0);
						step = emit(step, (c == CH_GT) ? KIND_LSR : KIND_ASR, c,
							1'b1, 1'b1);
						step.mode = MODE_IDLE;
					end else begin
						step = emit(step, KIND_ERR, CH_GT, 1'b1, 1'b1);
						step.mode = MODE_DRAIN;
					end
				end
				MODE_DRAIN: step.mode = MODE_DRAIN;
				default: step.mode = mode_q;
			endcase
		end
		// end of expression flushes the open token
		if (in_data.input_last) begin
			unique case (step.mode)
				MODE_DEC, MODE_BIN, MODE_HEX:
					step = emit(step, lit_kind(step.mode), 8'd0, 1'b0, 1'b1);
				MODE_ZERO: step = emit(step, KIND_DEC, CH_ZERO, 1'b1, 1'b1);
				MODE_LT: begin
					step = emit(step, KIND_ERR, CH_LT, 1'b1, 1'b1);
					step.mode = MODE_DRAIN;
				end
				MODE_GT: begin
					step = emit(step, KIND_ERR, CH_GT, 1'b1, 1'b1);
					step.mode = MODE_DRAIN;
				end
				default: step.mode = step.mode;
			endcase
			if (step.mode != MODE_DRAIN) begin
				step = emit(step, KIND_END, 8'd0, 1'b0, 1'b1);
			end
			step.mode = MODE_IDLE;
		end
		// mark the final result of this beat
		if (step.cnt != '0) begin
			step.res[ETS_RES_IDX_W'(step.cnt - CNT_W'(1))].run_last = 1'b1;
		end
	end

	assign in_stall = q_full;
	assign push = in_valid && !q_full && (step.cnt != '0);
	assign push_data.res = step.res;
	assign push_data.last_idx = ETS_RES_IDX_W'(step.cnt - CNT_W'(1));

	// scan mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (in_valid && !q_full) begin
			mode_q <= step.mode;
		end
	end

	// while draining, no beat produces a result; the last beat returns the mode to idle
	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !q_full && mode_q == MODE_DRAIN) |-> !push)
		else $error("result produced while draining after an error");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !q_full && in_data.input_last) |=> (mode_q == MODE_IDLE))
		else $error("scan mode not idle after end of expression");

endmodule

@@ sv/ets_queue.sv @@
// short bundle queue between front and back ends
module ets_queue #(
	parameter int DEPTH = ets_pkg::ETS_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ets_pkg::bundle_t push_data,
	output logic             full,
	output logic             not_empty,
	input  logic             pop,
	output ets_pkg::bundle_t head
);
	import ets_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	// storage, written only on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");

endmodule

@@ sv/ets_back.sv @@
// back end: plays out the results of the head bundle one beat at a time
module ets_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  ets_pkg::bundle_t head,
	output logic             pop,
	output logic             out_valid,
	output ets_pkg::result_t out_data,
	input  logic             out_stall
);
	import ets_pkg::*;

	logic [ETS_RES_IDX_W-1:0] idx_q;
	logic                     take;

	assign out_valid = not_empty;
	assign out_data = head.res[idx_q];
	assign take = out_valid && !out_stall;
	assign pop = take && (idx_q == head.last_idx);

	// slot index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + ETS_RES_IDX_W'(1);
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q <= head.last_idx))
		else $error("slot index past end of bundle");

endmodule

@@ sv/expression_token_scanner.sv @@
// Expression token scanner: a character per input beat in, token result beats out.
// A character's results go into the queue as a registered bundle, offered from its head.
// One character per cycle while each causes at most one result and output is unstalled;
// more results hold the output side as they play out, and the QDEPTH-bundle queue
// absorbs the difference. Reset: scan mode idle, queue empty, no result offered.
module expression_token_scanner #(
	parameter int QDEPTH = ets_pkg::ETS_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ets_pkg::in_t     in_data,
	output logic             in_stall,
	output logic             out_valid,
	output ets_pkg::result_t out_data,
	input  logic             out_stall
);
	import ets_pkg::*;

	logic    q_full;
	logic    q_not_empty;
	logic    push;
	logic    pop;
	bundle_t push_data;
	bundle_t head;

	// classify characters into bundles
	ets_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	ets_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.head      (head)
	);

	// result playout
	ets_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

endmodule

@@ test/testbench.sv @@
// testbench for the expression token scanner: predicted token beats checked against the block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ets_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 300;

	// scanner state as the predictor tracks it
	typedef enum logic [2:0] {
		SM_IDLE, SM_DEC, SM_BIN, SM_HEX, SM_ZERO, SM_LT, SM_GT, SM_DRAIN
	} scan_state_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid = 1'b0;
	in_t     in_data = '0;
	logic    in_stall;
	logic    out_valid;
	result_t out_data;
	logic    out_stall = 1'b0;

	scan_state_t scan_state = SM_IDLE;
	result_t     beat_tokens[$];
	result_t     tokens_due[$];
	logic [7:0]  expr_text[$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          send_calm = 0;
	int          stall_calm = 0;

	expression_token_scanner DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[expression_token_scanner] ERROR");
			$finish;
		end
	end

	// random pause length: mostly none, some short, a few long, with calm stretches
	function automatic int pause_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	// character classes
	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_hex(logic [7:0] c);
		return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// kind of a one-character operator, KIND_END when c is none
	function automatic kind_t op_kind(logic [7:0] c);
		case (c)
			"(": return KIND_LPAREN;
			")": return KIND_RPAREN;
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_MUL;
			"/": return KIND_DIV;
			"~": return KIND_NOT;
			"&": return KIND_AND;
			"|": return KIND_OR;
			"^": return KIND_XOR;
			default: return KIND_END;
		endcase
	endfunction

	function automatic kind_t literal_kind(scan_state_t s);
		case (s)
			SM_DEC: return KIND_DEC;
			SM_BIN: return KIND_BIN;
			default: return KIND_HEX;
		endcase
	endfunction

	function automatic void push_token(kind_t k, logic [7:0] text, bit has_text, bit fin);
		result_t r;
		r.token_kind = k;
		r.text_byte = has_text ? text : 8'h00;
		r.text_valid = has_text;
		r.token_end = fin;
		r.run_last = 1'b0;
		beat_tokens.push_back(r);
	endfunction

	// a character seen while no token is open
	function automatic void open_token(logic [7:0] c);
		kind_t k;
		k = op_kind(c);
		if (c == " " || c == "\t") begin
			scan_state = SM_IDLE;
		end else if (c == "0") begin
			scan_state = SM_ZERO;
		end else if (is_dec(c)) begin
			push_token(KIND_DEC, c, 1'b1, 1'b0);
			scan_state = SM_DEC;
		end else if (c == "<") begin
			scan_state = SM_LT;
		end else if (c == ">") begin
			scan_state = SM_GT;
		end else if (k != KIND_END) begin
			push_token(k, c, 1'b1, 1'b1);
			scan_state = SM_IDLE;
		end else begin
			push_token(KIND_ERR, c, 1'b1, 1'b1);
			scan_state = SM_DRAIN;
		end
	endfunction

	// one present character
	function automatic void scan_char(logic [7:0] c);
		bit more;
		case (scan_state)
			SM_IDLE: open_token(c);
			SM_DEC, SM_BIN, SM_HEX: begin
				more = (scan_state == SM_DEC) ? is_dec(c) :
				       (scan_state == SM_BIN) ? (c == "0" || c == "1") : is_hex(c);
				if (more) begin
					push_token(literal_kind(scan_state), c, 1'b1, 1'b0);
				end else begin
					push_token(literal_kind(scan_state), 8'h00, 1'b0, 1'b1);
					open_token(c);
				end
			end
			SM_ZERO: begin
				if (c == "b") begin
					scan_state = SM_BIN;
				end else if (c == "x") begin
					scan_state = SM_HEX;
				end else if (is_dec(c)) begin
					push_token(KIND_DEC, "0", 1'b1, 1'b0);
					push_token(KIND_DEC, c, 1'b1, 1'b0);
					scan_state = SM_DEC;
				end else begin
					push_token(KIND_DEC, "0", 1'b1, 1'b1);
					open_token(c);
				end
			end
			SM_LT: begin
				if (c == "<") begin
					push_token(KIND_LSL, "<", 1'b1, 1'b0);
					push_token(KIND_LSL, "<", 1'b1, 1'b1);
					scan_state = SM_IDLE;
				end else begin
					push_token(KIND_ERR, "<", 1'b1, 1'b1);
					scan_state = SM_DRAIN;
				end
			end
			SM_GT: begin
				if (c == ">" || c == "-") begin
					push_token(c == ">" ? KIND_LSR : KIND_ASR, ">", 1'b1, 1'b0);
					push_token(c == ">" ? KIND_LSR : KIND_ASR, c, 1'b1, 1'b1);
					scan_state = SM_IDLE;
				end else begin
					push_token(KIND_ERR, ">", 1'b1, 1'b1);
					scan_state = SM_DRAIN;
				end
			end
			default: ;
		endcase
	endfunction

	// end of expression: flush the open token, then the end token unless draining
	function automatic void close_expr();
		case (scan_state)
			SM_DEC, SM_BIN, SM_HEX: push_token(literal_kind(scan_state), 8'h00, 1'b0, 1'b1);
			SM_ZERO: push_token(KIND_DEC, "0", 1'b1, 1'b1);
			SM_LT: begin
				push_token(KIND_ERR, "<", 1'b1, 1'b1);
				scan_state = SM_DRAIN;
			end
			SM_GT: begin
				push_token(KIND_ERR, ">", 1'b1, 1'b1);
				scan_state = SM_DRAIN;
			end
			default: ;
		endcase
		if (scan_state != SM_DRAIN)
			push_token(KIND_END, 8'h00, 1'b0, 1'b1);
		scan_state = SM_IDLE;
	endfunction

	// expected token beats of one accepted input beat
	function automatic void scan_beat(in_t b);
		beat_tokens.delete();
		if (b.byte_present)
			scan_char(b.char_byte);
		if (b.input_last)
			close_expr();
		if (beat_tokens.size() > 0)
			beat_tokens[beat_tokens.size() - 1].run_last = 1'b1;
		foreach (beat_tokens[i])
			tokens_due.push_back(beat_tokens[i]);
	endfunction

	// send one input beat; valid stays high afterwards unless a gap follows
	task automatic send_beat(logic [7:0] c, bit present, bit fin);
		int gap;
		in_t b;
		b.char_byte = c;
		b.byte_present = present;
		b.input_last = fin;
		gap = pause_len(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		scan_beat(b);
	endtask

	task automatic send_text(string s, bit fin);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b1, fin && i == s.len() - 1);
	endtask

	// output side stall pattern
	initial begin
		int n;
		forever begin
			n = pause_len(stall_calm);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// compare each accepted result beat with the oldest expected one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tokens_due.size() == 0) begin
				$error("unexpected result beat: kind %0d text %0h", out_data.token_kind,
					out_data.text_byte);
				fail_count++;
			end else begin
				want = tokens_due.pop_front();
				if (out_data.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d, got %0d", want.token_kind,
						out_data.token_kind);
					fail_count++;
				end
				if (out_data.text_byte !== want.text_byte) begin
					$error("text_byte: expected %0h, got %0h", want.text_byte,
						out_data.text_byte);
					fail_count++;
				end
				if (out_data.text_valid !== want.text_valid) begin
					$error("text_valid: expected %0b, got %0b", want.text_valid,
						out_data.text_valid);
					fail_count++;
				end
				if (out_data.token_end !== want.token_end) begin
					$error("token_end: expected %0b, got %0b", want.token_end,
						out_data.token_end);
					fail_count++;
				end
				if (out_data.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last,
						out_data.run_last);
					fail_count++;
				end
			end
		end
	end

	// every single and double operator
	task automatic test_operators();
		send_text("(+)-*/~&|^<<>>>-", 1'b1);
	endtask

	// literals: prefixes, mixed-case hex, held zero, empty literals
	task automatic test_literals();
		send_text("0b1 0xaF\t09 0x", 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		send_text("0b+0", 1'b1);
	endtask

	// invalid bytes, lone angles, draining up to the end
	task automatic test_errors();
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b1);
		send_text("<5", 1'b1);
		send_text(">", 1'b1);
		send_text("3g", 1'b1);
	endtask

	// items with no byte, with and without the end mark
	task automatic test_end_only();
		send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_text("7", 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// append one random token, mostly well formed
	function automatic void add_token();
		string ops;
		string hexd;
		string pairs;
		int n;
		int p;
		ops = "()+-*/~&|^";
		hexd = "0123456789abcdefABCDEF";
		pairs = "<<>>>-";
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				n = $urandom_range(1, 4);
				repeat (n) expr_text.push_back(8'("0" + $urandom_range(0, 9)));
			end
			4, 5: begin
				expr_text.push_back("0");
				expr_text.push_back("b");
				n = $urandom_range(0, 4);
				repeat (n) expr_text.push_back(8'("0" + $urandom_range(0, 1)));
			end
			6, 7: begin
				expr_text.push_back("0");
				expr_text.push_back("x");
				n = $urandom_range(0, 4);
				repeat (n) expr_text.push_back(hexd[$urandom_range(0, 21)]);
			end
			8, 9, 10, 11, 12, 13: expr_text.push_back(ops[$urandom_range(0, 9)]);
			14, 15, 16: begin
				p = 2 * $urandom_range(0, 2);
				expr_text.push_back(pairs[p]);
				expr_text.push_back(pairs[p + 1]);
			end
			17: expr_text.push_back($urandom_range(0, 1) ? " " : "\t");
			18: expr_text.push_back($urandom_range(0, 1) ? "<" : ">");
			default: expr_text.push_back(8'($urandom_range(0, 255)));
		endcase
		if ($urandom_range(0, 1))
			expr_text.push_back($urandom_range(0, 3) ? " " : "\t");
	endfunction

	// random expressions until enough items have gone in
	task automatic test_random_expressions();
		int sent;
		int n;
		bit end_only;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			expr_text.delete();
			n = $urandom_range(1, 8);
			repeat (n) add_token();
			end_only = ($urandom_range(0, 9) < 3);
			foreach (expr_text[i]) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				send_beat(expr_text[i], 1'b1,
					!end_only && i == expr_text.size() - 1);
				sent++;
			end
			if (end_only) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				sent++;
			end
		end
	endtask

	// reset, tests in turn, drain, verdict
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_operators();
		test_literals();
		test_errors();
		test_end_only();
		test_random_expressions();
		in_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[expression_token_scanner] OK");
		else
			$display("[expression_token_scanner] ERROR");
		$finish;
	end

endmodule
